// ===== hw/rtl/sfd_pkg.sv =====
// shared types and constants of the slip frame decoder
package sfd_pkg;

    // slip special bytes
    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    // register map
    localparam logic       REG_EXPECTED_LENGTH   = 1'b0;
    localparam logic [5:0] EXPECTED_LENGTH_RESET = 6'd10;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        CMD_STORE,
        CMD_CLOSE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic {
        BK_COLLECT,
        BK_EMIT
    } t_back_state;

endpackage

// ===== hw/rtl/sfd_if.sv =====
// item channels of the slip frame decoder

interface sfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       frame_last;

    modport source (output valid, output payload_byte, output frame_last, input ready);
    modport sink (input valid, input payload_byte, input frame_last, output ready);
endinterface

// ===== hw/rtl/sfd_front.sv =====
// front end: framing and escape classification of received bytes
module sfd_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [7:0]   i_rx_byte,
    output logic         o_ready,
    input  logic         i_queue_full,
    output logic         o_push,
    output sfd_pkg::t_cmd o_cmd
);

    logic r_inside_frame;
    logic r_escape_pending;
    logic n_inside_frame;
    logic n_escape_pending;
    logic accept;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && !i_queue_full;

    always_comb begin
        n_inside_frame   = r_inside_frame;
        n_escape_pending = r_escape_pending;
        o_push           = 1'b0;
        o_cmd.kind       = sfd_pkg::CMD_STORE;
        o_cmd.data       = i_rx_byte;
        if (accept) begin
            if (i_rx_byte == sfd_pkg::SLIP_END) begin
                // delimiter closes the current frame, if any
                o_push           = r_inside_frame;
                o_cmd.kind       = sfd_pkg::CMD_CLOSE;
                n_inside_frame   = 1'b1;
                n_escape_pending = 1'b0;
            end else if (r_inside_frame) begin
                if (r_escape_pending) begin
                    n_escape_pending = 1'b0;
                    if (i_rx_byte == sfd_pkg::SLIP_ESC_END) begin
                        o_push     = 1'b1;
                        o_cmd.data = sfd_pkg::SLIP_END;
                    end else if (i_rx_byte == sfd_pkg::SLIP_ESC_ESC) begin
                        o_push     = 1'b1;
                        o_cmd.data = sfd_pkg::SLIP_ESC;
                    end
                end else if (i_rx_byte == sfd_pkg::SLIP_ESC) begin
                    n_escape_pending = 1'b1;
                end else begin
                    o_push = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside_frame   <= 1'b0;
            r_escape_pending <= 1'b0;
        end else begin
            r_inside_frame   <= n_inside_frame;
            r_escape_pending <= n_escape_pending;
        end
    end

endmodule

// ===== hw/rtl/sfd_queue.sv =====
// short command queue between front and back
module sfd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sfd_pkg::t_cmd o_cmd
);

    localparam int PW = (sfd_pkg::QUEUE_DEPTH > 1) ? $clog2(sfd_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(sfd_pkg::QUEUE_DEPTH + 1);

    sfd_pkg::t_cmd r_entry [sfd_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(sfd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(sfd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(sfd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/sfd_back.sv =====
// back end: frame buffer, length check and byte-wise frame delivery
module sfd_back #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [5:0]    i_expected_length,
    input  logic          i_cmd_valid,
    input  sfd_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_payload_byte,
    output logic          o_frame_last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int FW = $clog2(MAX_PAYLOAD + 1);
    localparam int LW = (FW > 6) ? FW : 6;

    sfd_pkg::t_back_state r_state;
    sfd_pkg::t_back_state n_state;

    logic [7:0]    r_store [MAX_PAYLOAD];
    logic [FW-1:0] r_fill;
    logic          r_too_long;
    logic [AW-1:0] r_idx;
    logic          r_out_valid;
    logic [7:0]    r_out_data;
    logic          r_out_last;

    logic pop;
    logic issue;
    logic deliver;
    logic is_last;
    logic has_room;

    assign deliver  = (r_fill != '0) && !r_too_long &&
                      (LW'(r_fill) == LW'(i_expected_length));
    assign is_last  = ((FW'(r_idx) + FW'(1)) == r_fill);
    assign has_room = (r_fill < FW'(MAX_PAYLOAD));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfd_pkg::BK_COLLECT: begin
                if (pop && i_cmd.kind == sfd_pkg::CMD_CLOSE && deliver) begin
                    n_state = sfd_pkg::BK_EMIT;
                end
            end
            sfd_pkg::BK_EMIT: begin
                if (issue && is_last) begin
                    n_state = sfd_pkg::BK_COLLECT;
                end
            end
            default: n_state = sfd_pkg::BK_COLLECT;
        endcase
    end

    // state outputs
    always_comb begin
        pop   = 1'b0;
        issue = 1'b0;
        unique case (r_state)
            sfd_pkg::BK_COLLECT: pop = i_cmd_valid;
            sfd_pkg::BK_EMIT:    issue = !r_out_valid || i_out_ready;
            default: begin
                pop   = 1'b0;
                issue = 1'b0;
            end
        endcase
    end

    assign o_cmd_pop      = pop;
    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out_data;
    assign o_frame_last   = r_out_last;

    // frame buffer, read data lands straight in the output register
    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.kind == sfd_pkg::CMD_STORE && has_room) begin
            r_store[r_fill[AW-1:0]] <= i_cmd.data;
        end
        if (issue) begin
            r_out_data <= r_store[r_idx];
            r_out_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfd_pkg::BK_COLLECT;
            r_fill      <= '0;
            r_too_long  <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop) begin
                if (i_cmd.kind == sfd_pkg::CMD_STORE) begin
                    if (has_room) begin
                        r_fill <= r_fill + FW'(1);
                    end else begin
                        r_too_long <= 1'b1;
                    end
                end else if (deliver) begin
                    r_idx <= '0;
                end else begin
                    r_fill     <= '0;
                    r_too_long <= 1'b0;
                end
            end
            if (issue) begin
                r_idx <= r_idx + 1'b1;
                if (is_last) begin
                    r_fill     <= '0;
                    r_too_long <= 1'b0;
                end
            end
            if (issue) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // fill count never runs past the buffer
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(MAX_PAYLOAD))
        else $error("frame fill beyond buffer");

    // a delivered frame is non-empty and did not overflow
    a_emit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfd_pkg::BK_EMIT) |-> (r_fill != '0 && !r_too_long))
        else $error("emitting a frame that should be discarded");

    // emission only starts on a closing command
    a_emit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfd_pkg::BK_COLLECT && n_state == sfd_pkg::BK_EMIT)
            |-> (pop && i_cmd.kind == sfd_pkg::CMD_CLOSE))
        else $error("emission started without a delimiter");

    // the emit index stays inside the frame
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfd_pkg::BK_EMIT) |-> (FW'(r_idx) < r_fill))
        else $error("emit index past frame end");

endmodule

// ===== hw/rtl/slip_frame_decoder.sv =====
// top level of the slip frame decoder: configuration port and block wiring
//
// slip receive-side decoder. raw serial bytes enter on i_rx one item per
// cycle while i_rx.ready is high; 0xC0 delimits frames, bytes before the
// first delimiter are ignored, 0xDB escapes the next byte (0xDC -> 0xC0,
// 0xDD -> 0xDB, anything else is dropped with the escape). decoded bytes
// collect in a MAX_PAYLOAD-byte frame buffer. at a delimiter, a non-empty
// frame that did not overflow and whose length equals expected_length
// (register 0, byte address 0, 6 bits, reset 10) is sent out on o_pl one byte
// per item with frame_last on its final byte; every other frame is silently
// discarded. a front stage classifies each received byte in the cycle it is
// accepted and hands store/close commands to a two-entry queue; a back stage
// owns the buffer. a delivering delimiter holds the back stage while it reads
// out the buffered bytes (single buffer read port, one byte per cycle while
// o_pl does not stall), during which the queue absorbs up to two more
// commands before i_rx.ready drops. the buffer needs no clearing after reset.
module slip_frame_decoder #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfd_rx_if.sink      i_rx,
    sfd_out_if.source   o_pl,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [5:0]    r_expected_length;
    logic          cfg_write;
    logic          q_full;
    logic          front_push;
    sfd_pkg::t_cmd front_cmd;
    logic          q_valid;
    logic          q_pop;
    sfd_pkg::t_cmd q_cmd;

    // apb: zero wait states, word index from paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == sfd_pkg::REG_EXPECTED_LENGTH) ?
                       32'(r_expected_length) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_length <= sfd_pkg::EXPECTED_LENGTH_RESET;
        end else if (cfg_write && paddr[2] == sfd_pkg::REG_EXPECTED_LENGTH) begin
            r_expected_length <= pwdata[5:0];
        end
    end

    // framing and escape handling
    sfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_rx.valid),
        .i_rx_byte    (i_rx.rx_byte),
        .o_ready      (i_rx.ready),
        .i_queue_full (q_full),
        .o_push       (front_push),
        .o_cmd        (front_cmd)
    );

    // decouples byte intake from frame delivery
    sfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // frame buffer and delivery
    sfd_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_expected_length (r_expected_length),
        .i_cmd_valid       (q_valid),
        .i_cmd             (q_cmd),
        .o_cmd_pop         (q_pop),
        .o_out_valid       (o_pl.valid),
        .i_out_ready       (o_pl.ready),
        .o_payload_byte    (o_pl.payload_byte),
        .o_frame_last      (o_pl.frame_last)
    );

endmodule

// ===== test/tb_slip_frame_decoder.sv =====
// testbench of the slip frame decoder: directed and random byte streams with a scoreboard
`timescale 1ns / 1ps

module tb_slip_frame_decoder;

    localparam int MAX_PAYLOAD   = 32;
    // back stage may still chew on queued commands after the last delivered byte
    localparam int SETTLE_CYCLES = 16;
    // worst case is far below this: ~460 items, each with long gaps and long output stalls
    localparam int LIMIT_NS      = 3_000_000;
    localparam int REPORT_MAX    = 10;

    // register map: one register, byte address 4*i
    localparam logic [2:0] ADDR_LEN   = {sfd_pkg::REG_EXPECTED_LENGTH, 2'b00};
    localparam logic [2:0] ADDR_SPARE = {~sfd_pkg::REG_EXPECTED_LENGTH, 2'b00};

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_slip_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sfd_rx_if  rx_if ();
    sfd_out_if pl_if ();

    slip_frame_decoder #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if.sink),
        .o_pl    (pl_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder state as the testbench sees it
    logic [5:0]  exp_len = sfd_pkg::EXPECTED_LENGTH_RESET;
    bit          frame_open;
    bit          esc_pending;
    bit          too_long;
    int unsigned fill;
    logic [7:0]  frame_buf [MAX_PAYLOAD];

    // payload bytes still owed by the block, oldest first
    t_slip_out   owed_bytes [$];

    int          errors;
    int          items_sent;
    bit          tx_steady;     // sender offers items back to back
    bit          rx_steady;     // receiver always ready
    int          hold_request;  // long receiver hold-off, picked up by the receiver

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic void buffer_byte(input logic [7:0] b);
        if (fill < MAX_PAYLOAD) begin
            frame_buf[fill] = b;
            fill++;
        end else begin
            too_long = 1'b1;
        end
    endfunction

    // one raw byte in, the delivered payload bytes (if any) onto owed_bytes
    function automatic void predict_slip_byte(input logic [7:0] b);
        t_slip_out o;
        if (b == sfd_pkg::SLIP_END) begin
            // delimiter closes the frame; deliver only a clean frame of the set length
            if (frame_open && fill > 0 && !too_long && fill == exp_len) begin
                for (int i = 0; i < fill; i++) begin
                    o.data = frame_buf[i];
                    o.last = (i + 1 == fill);
                    owed_bytes = {owed_bytes, o};
                end
            end
            fill        = 0;
            too_long    = 1'b0;
            frame_open  = 1'b1;
            esc_pending = 1'b0;
        end else if (frame_open) begin
            if (esc_pending) begin
                // escaped byte: only the two escape codes survive
                if (b == sfd_pkg::SLIP_ESC_END)
                    buffer_byte(sfd_pkg::SLIP_END);
                else if (b == sfd_pkg::SLIP_ESC_ESC)
                    buffer_byte(sfd_pkg::SLIP_ESC);
                esc_pending = 1'b0;
            end else if (b == sfd_pkg::SLIP_ESC) begin
                esc_pending = 1'b1;
            end else begin
                buffer_byte(b);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what, input int want, input int got);
        errors++;
        if (errors <= REPORT_MAX)
            $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    endtask

    // every accepted payload byte is matched against the oldest owed one
    always @(posedge i_clk) begin : check_payload
        t_slip_out want;
        if (i_rst_n && pl_if.valid && pl_if.ready) begin
            if (owed_bytes.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected payload byte %0h last %0b",
                             pl_if.payload_byte, pl_if.frame_last);
            end else begin
                want = owed_bytes.pop_front();
                if (pl_if.payload_byte !== want.data)
                    note_mismatch("payload_byte", want.data, pl_if.payload_byte);
                if (pl_if.frame_last !== want.last)
                    note_mismatch("frame_last", want.last, pl_if.frame_last);
            end
        end
    end

    // ------------------------------------------------------------------
    // idling
    // ------------------------------------------------------------------

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // receiver: random stalls, quiet stretches, and the long hold-off on request
    initial begin : drive_ready
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        pl_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                pl_if.ready <= 1'b0;
                hold_left--;
            end else if (rx_steady) begin
                pl_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                pl_if.ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 3) != 0) begin
                pl_if.ready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                pl_if.ready <= (stall_left == 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // offer one raw byte and wait until it is taken; valid stays up afterwards
    // so a following item can go out back to back
    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        predict_slip_byte(b);
        items_sent++;
    endtask

    // stop offering, wait for every owed byte, then let the back stage go quiet
    task automatic settle();
        rx_if.valid <= 1'b0;
        while (owed_bytes.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // idle cycle between transfers
        @(posedge i_clk);
        // only the length register exists; other indexes are ignored
        if (addr[2] == sfd_pkg::REG_EXPECTED_LENGTH)
            exp_len = data[5:0];
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        // take read data mid access cycle, away from the edge
        do begin
            @(negedge i_clk);
            data = prdata;
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        // idle cycle between transfers
        @(posedge i_clk);
    endtask

    task automatic check_length_reg();
        logic [31:0] rd;
        apb_read(ADDR_LEN, rd);
        if (rd !== {26'd0, exp_len})
            note_mismatch("expected_length readback", {26'd0, exp_len}, rd);
    endtask

    // new payload length, written while idle, with junk in the unused upper bits
    task automatic set_length(input logic [5:0] len);
        logic [31:0] wdata;
        settle();
        wdata      = $urandom();
        wdata[5:0] = len;
        apb_write(ADDR_LEN, wdata);
        check_length_reg();
    endtask

    // content biased toward the bytes that need escaping and the extremes
    function automatic logic [7:0] pick_payload();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return sfd_pkg::SLIP_END;
        else if (r < 16)
            return sfd_pkg::SLIP_ESC;
        else if (r < 20)
            return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        else if (r < 24)
            return ($urandom_range(0, 1) != 0) ? sfd_pkg::SLIP_ESC_END
                                               : sfd_pkg::SLIP_ESC_ESC;
        else
            return $urandom_range(0, 255);
    endfunction

    // one encoded frame of n payload bytes plus its closing delimiter
    task automatic send_frame(input int n, input bit add_stray, input bit esc_before_end);
        int         stray_at;
        logic [7:0] d;
        logic [7:0] junk;
        stray_at = add_stray ? $urandom_range(0, n) : -1;
        for (int i = 0; i <= n; i++) begin
            if (i == stray_at) begin
                // escape followed by a byte that is no escape code: both dropped
                do junk = $urandom_range(0, 255);
                while (junk == sfd_pkg::SLIP_END || junk == sfd_pkg::SLIP_ESC_END ||
                       junk == sfd_pkg::SLIP_ESC_ESC);
                send_rx_byte(sfd_pkg::SLIP_ESC);
                send_rx_byte(junk);
            end
            if (i < n) begin
                d = pick_payload();
                if (d == sfd_pkg::SLIP_END) begin
                    send_rx_byte(sfd_pkg::SLIP_ESC);
                    send_rx_byte(sfd_pkg::SLIP_ESC_END);
                end else if (d == sfd_pkg::SLIP_ESC) begin
                    send_rx_byte(sfd_pkg::SLIP_ESC);
                    send_rx_byte(sfd_pkg::SLIP_ESC_ESC);
                end else begin
                    send_rx_byte(d);
                end
            end
        end
        if (esc_before_end)
            send_rx_byte(sfd_pkg::SLIP_ESC);
        send_rx_byte(sfd_pkg::SLIP_END);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_register_map();
        logic [31:0] rd;
        // reset value first, then a write to the unused index must change nothing
        check_length_reg();
        apb_write(ADDR_SPARE, $urandom());
        check_length_reg();
        apb_write(ADDR_SPARE, 32'hFFFF_FFFF);
        apb_read(ADDR_LEN, rd);
        if (rd !== {26'd0, exp_len})
            note_mismatch("length after unused write", {26'd0, exp_len}, rd);
    endtask

    // garbage before the first delimiter, an escape among it, is ignored
    task automatic test_pre_frame_noise();
        send_rx_byte(8'h00);
        send_rx_byte(8'hFF);
        send_rx_byte(sfd_pkg::SLIP_ESC);
        send_rx_byte(sfd_pkg::SLIP_ESC_ESC);
        send_rx_byte(sfd_pkg::SLIP_END);
    endtask

    // two delimiters in a row deliver nothing
    task automatic test_empty_frame();
        send_rx_byte(sfd_pkg::SLIP_END);
    endtask

    task automatic test_escapes();
        set_length(6'd2);
        send_rx_byte(sfd_pkg::SLIP_ESC);
        send_rx_byte(sfd_pkg::SLIP_ESC_END);
        send_rx_byte(sfd_pkg::SLIP_ESC);
        send_rx_byte(sfd_pkg::SLIP_ESC_ESC);
        send_rx_byte(sfd_pkg::SLIP_END);
    endtask

    task automatic test_stray_escape();
        send_rx_byte(sfd_pkg::SLIP_ESC);
        send_rx_byte(8'h41);
        send_rx_byte(8'h00);
        send_rx_byte(8'hFF);
        send_rx_byte(sfd_pkg::SLIP_END);
    endtask

    // the delimiter wins over a pending escape, and the escape does not linger
    task automatic test_escape_then_delimiter();
        send_rx_byte(8'h7E);
        send_rx_byte(sfd_pkg::SLIP_ESC);
        send_rx_byte(sfd_pkg::SLIP_END);
        send_rx_byte(sfd_pkg::SLIP_ESC_END);
        send_rx_byte(sfd_pkg::SLIP_ESC_ESC);
        send_rx_byte(sfd_pkg::SLIP_END);
    endtask

    task automatic test_length_mismatch();
        send_rx_byte(8'h01);
        send_rx_byte(sfd_pkg::SLIP_END);
    endtask

    // receiver holds off while the sender keeps pushing full frames,
    // so the command queue fills and the input has to stall
    task automatic test_backpressure();
        set_length(6'd4);
        tx_steady    = 1'b1;
        hold_request = 150;
        repeat (5) send_frame(4, 1'b0, 1'b0);
        tx_steady = 1'b0;
    endtask

    // phases with different lengths, the extremes among them; one phase runs with no idling
    task automatic test_random();
        int phase_len    [7] = '{1, 32, 0, 63, 5, -1, -1};
        int phase_budget [7] = '{45, 75, 20, 20, 60, 55, 65};
        int len;
        int start;
        int r;
        int n_ok;
        for (int p = 0; p < 7; p++) begin
            len = (phase_len[p] < 0) ? $urandom_range(1, MAX_PAYLOAD) : phase_len[p];
            set_length(len[5:0]);
            tx_steady = (p == 4);
            rx_steady = (p == 4);
            start     = items_sent;
            while (items_sent - start < phase_budget[p]) begin
                n_ok = (len >= 1 && len <= MAX_PAYLOAD) ? len : $urandom_range(0, 36);
                r    = $urandom_range(0, 99);
                if (r < 65)
                    send_frame(n_ok, 1'b0, 1'b0);
                else if (r < 75)
                    send_frame($urandom_range(0, MAX_PAYLOAD + 2), 1'b0, 1'b0);
                else if (r < 80)
                    send_frame($urandom_range(MAX_PAYLOAD + 1, MAX_PAYLOAD + 6), 1'b0, 1'b0);
                else if (r < 88)
                    send_frame(n_ok, 1'b1, 1'b0);
                else if (r < 94)
                    send_frame($urandom_range(0, n_ok), 1'b0, 1'b1);
                else
                    send_rx_byte(sfd_pkg::SLIP_END);
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n       <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= 3'd0;
        pwdata        <= 32'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_map();
        test_pre_frame_noise();
        test_empty_frame();
        test_escapes();
        test_stray_escape();
        test_escape_then_delimiter();
        test_length_mismatch();
        test_backpressure();
        test_random();

        settle();
        errors += owed_bytes.size();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
